FILE: sv/lpr_pkg.sv
// Package for the line pixel rasteriser: request and response words,
// line state record, line modes and operation codes. No dependencies.
package lpr_pkg;

   localparam int unsigned CoordWidth = 8;
   localparam int unsigned ErrWidth   = 10;

   typedef logic [CoordWidth-1:0] coord_type;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MODE_VERT = 2'd0,
      MODE_HORZ = 2'd1,
      MODE_XMAJ = 2'd2,
      MODE_YMAJ = 2'd3
   } line_mode_type;

   typedef struct packed {
      op_type    op;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      logic      color;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      pixel_color;
      logic      last;
   } rsp_type;

   typedef struct packed {
      coord_type            cur_x;
      coord_type            cur_y;
      coord_type            stop_x;
      coord_type            stop_y;
      coord_type            span_x;
      coord_type            span_y;
      logic [ErrWidth-1:0]  error_acc;
      logic                 step_neg_x;
      logic                 step_neg_y;
      line_mode_type        line_mode;
      logic                 busy;
      logic                 held_color;
   } line_state_type;

endpackage

FILE: sv/line_pixel_rasterizer.sv
// Top level of the line pixel rasteriser: input register, line state,
// start decode, pixel step and response register. Depends on lpr_pkg,
// lpr_setup and lpr_step.
//
//   channel   ports                          direction  word
//   request   req_valid req_ready req_data   in         req_type
//   response  rsp_valid rsp_ready rsp_data   out        rsp_type
//
// A request word is held in the input register, then decoded, stepped and
// written to the response register unless it is an advance to an idle line.
// A new word is taken every cycle unless the response stalls. The speed is
// set by the single step path: start decode, one Bresenham add and compare.
// Synchronous reset clears the line state to idle and empties both registers.
// A stalled response holds the input register, which then holds req_ready low.
module line_pixel_rasterizer
   import lpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic           in_valid_ff, in_valid_in;
   req_type        in_word_ff;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_word_ff;
   line_state_type state_ff, state_in;

   line_state_type init_state;
   line_state_type work_state;
   line_state_type next_state;
   rsp_type        pixel;
   logic           is_start;
   logic           produces;
   logic           process;

   lpr_setup u_setup (
      .req        (in_word_ff),
      .init_state (init_state)
   );

   assign is_start   = (in_word_ff.op == OP_START);
   assign work_state = is_start ? init_state : state_ff;
   assign produces   = is_start || state_ff.busy;

   lpr_step u_step (
      .cur_state  (work_state),
      .pixel      (pixel),
      .next_state (next_state)
   );

   assign process   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || process;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff && !rsp_ready;
      state_in     = state_ff;
      if (process) begin
         out_valid_in = produces;
         if (produces) begin
            state_in = next_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
      if (process && produces) begin
         out_word_ff <= pixel;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

FILE: sv/lpr_setup.sv
// Start decode: turns the endpoints and colour of a start word into the
// initial line state. Depends on lpr_pkg.
module lpr_setup
   import lpr_pkg::*;
(
   input  req_type        req,
   output line_state_type init_state
);

   coord_type x1, y1, x2, y2;
   logic      neg_x, neg_y;
   coord_type span_x, span_y;

   assign x1 = req.start_x;
   assign y1 = req.start_y;
   assign x2 = req.end_x;
   assign y2 = req.end_y;
   assign neg_x  = (x2 < x1);
   assign neg_y  = (y2 < y1);
   assign span_x = neg_x ? (x1 - x2) : (x2 - x1);
   assign span_y = neg_y ? (y1 - y2) : (y2 - y1);

   always_comb begin
      init_state            = '0;
      init_state.span_x     = span_x;
      init_state.span_y     = span_y;
      init_state.step_neg_x = neg_x;
      init_state.step_neg_y = neg_y;
      init_state.error_acc  = '0;
      init_state.busy       = 1'b1;
      init_state.held_color = req.color;
      if (x1 == x2) begin
         init_state.line_mode = MODE_VERT;
         init_state.cur_x     = x1;
         init_state.stop_x    = x1;
         init_state.cur_y     = neg_y ? y2 : y1;
         init_state.stop_y    = neg_y ? y1 : y2;
      end else if (y1 == y2) begin
         init_state.line_mode = MODE_HORZ;
         init_state.cur_y     = y1;
         init_state.stop_y    = y1;
         init_state.cur_x     = neg_x ? x2 : x1;
         init_state.stop_x    = neg_x ? x1 : x2;
      end else begin
         init_state.line_mode = (span_x > span_y) ? MODE_XMAJ : MODE_YMAJ;
         init_state.cur_x     = x1;
         init_state.cur_y     = y1;
         init_state.stop_x    = x2;
         init_state.stop_y    = y2;
      end
   end

endmodule

FILE: sv/lpr_step.sv
// Pixel step: emits the current pixel of a line and works out the state
// for the next one with a single Bresenham update. Depends on lpr_pkg.
module lpr_step
   import lpr_pkg::*;
(
   input  line_state_type cur_state,
   output rsp_type        pixel,
   output line_state_type next_state
);

   localparam int unsigned CmpWidth = ErrWidth + 2;

   coord_type                  x_step, y_step;
   coord_type                  major_span, minor_span;
   logic signed [ErrWidth-1:0] err_sum;
   logic signed [CmpWidth-1:0] err_twice;
   logic signed [CmpWidth-1:0] major_ext;
   logic                       minor_move;
   logic                       fin;

   assign x_step = cur_state.step_neg_x ? (cur_state.cur_x - coord_type'(1))
                                        : (cur_state.cur_x + coord_type'(1));
   assign y_step = cur_state.step_neg_y ? (cur_state.cur_y - coord_type'(1))
                                        : (cur_state.cur_y + coord_type'(1));

   assign major_span = (cur_state.line_mode == MODE_XMAJ) ? cur_state.span_x : cur_state.span_y;
   assign minor_span = (cur_state.line_mode == MODE_XMAJ) ? cur_state.span_y : cur_state.span_x;

   assign err_sum    = $signed(cur_state.error_acc)
                     + $signed({{(ErrWidth-CoordWidth){1'b0}}, minor_span});
   assign err_twice  = {err_sum[ErrWidth-1], err_sum, 1'b0};
   assign major_ext  = $signed({{(CmpWidth-CoordWidth){1'b0}}, major_span});
   assign minor_move = (err_twice >= major_ext);

   always_comb begin
      next_state = cur_state;
      fin        = 1'b0;
      case (cur_state.line_mode)
         MODE_VERT: begin
            fin = (cur_state.cur_y == cur_state.stop_y);
            if (!fin) begin
               next_state.cur_y = cur_state.cur_y + coord_type'(1);
            end
         end
         MODE_HORZ: begin
            fin = (cur_state.cur_x == cur_state.stop_x);
            if (!fin) begin
               next_state.cur_x = cur_state.cur_x + coord_type'(1);
            end
         end
         MODE_XMAJ: begin
            next_state.cur_x = x_step;
            fin              = (x_step == cur_state.stop_x);
            next_state.error_acc = err_sum;
            if (minor_move) begin
               next_state.cur_y     = y_step;
               next_state.error_acc = err_sum
                  - $signed({{(ErrWidth-CoordWidth){1'b0}}, major_span});
            end
         end
         default: begin
            next_state.cur_y = y_step;
            fin              = (y_step == cur_state.stop_y);
            next_state.error_acc = err_sum;
            if (minor_move) begin
               next_state.cur_x     = x_step;
               next_state.error_acc = err_sum
                  - $signed({{(ErrWidth-CoordWidth){1'b0}}, major_span});
            end
         end
      endcase
      next_state.busy = !fin;
   end

   always_comb begin
      pixel.pixel_x     = cur_state.cur_x;
      pixel.pixel_y     = cur_state.cur_y;
      pixel.pixel_color = cur_state.held_color;
      pixel.last        = fin;
   end

endmodule

FILE: dv/line_pixel_rasterizer_checker.sv
// Checker for the line pixel rasteriser: watches the request and response channels,
// predicts each pixel word from its own copy of the line state and compares.
// Depends on lpr_pkg.
module line_pixel_rasterizer_checker
   import lpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pixels_pending
);

   rsp_type       expected_pixels[$];
   rsp_type       want;
   coord_type     pen_x, pen_y, goal_x, goal_y, run_x, run_y;
   int            err_sum;
   logic          back_x, back_y, drawing, ink;
   line_mode_type walk;

   function automatic coord_type nudge(coord_type v, logic down);
      return down ? v - 8'd1 : v + 8'd1;
   endfunction

   task automatic plot_next();
      rsp_type px;
      logic    fin;
      px.pixel_x     = pen_x;
      px.pixel_y     = pen_y;
      px.pixel_color = ink;
      fin            = 1'b0;
      case (walk)
         MODE_VERT: begin
            fin = (pen_y == goal_y);
            if (!fin) pen_y = pen_y + 8'd1;
         end
         MODE_HORZ: begin
            fin = (pen_x == goal_x);
            if (!fin) pen_x = pen_x + 8'd1;
         end
         MODE_XMAJ: begin
            pen_x   = nudge(pen_x, back_x);
            fin     = (pen_x == goal_x);
            err_sum = err_sum + int'(run_y);
            if (2 * err_sum >= int'(run_x)) begin
               pen_y   = nudge(pen_y, back_y);
               err_sum = err_sum - int'(run_x);
            end
         end
         default: begin
            pen_y   = nudge(pen_y, back_y);
            fin     = (pen_y == goal_y);
            err_sum = err_sum + int'(run_x);
            if (2 * err_sum >= int'(run_y)) begin
               pen_x   = nudge(pen_x, back_x);
               err_sum = err_sum - int'(run_y);
            end
         end
      endcase
      px.last = fin;
      drawing = !fin;
      expected_pixels.push_back(px);
   endtask

   task automatic trace_request(req_type w);
      if (w.op == OP_ADVANCE) begin
         if (drawing) plot_next();
      end else begin
         ink     = w.color;
         err_sum = 0;
         back_x  = (w.end_x < w.start_x);
         back_y  = (w.end_y < w.start_y);
         run_x   = back_x ? w.start_x - w.end_x : w.end_x - w.start_x;
         run_y   = back_y ? w.start_y - w.end_y : w.end_y - w.start_y;
         if (w.start_x == w.end_x) begin
            walk   = MODE_VERT;
            pen_x  = w.start_x;
            goal_x = w.start_x;
            pen_y  = back_y ? w.end_y : w.start_y;
            goal_y = back_y ? w.start_y : w.end_y;
         end else if (w.start_y == w.end_y) begin
            walk   = MODE_HORZ;
            pen_y  = w.start_y;
            goal_y = w.start_y;
            pen_x  = back_x ? w.end_x : w.start_x;
            goal_x = back_x ? w.start_x : w.end_x;
         end else begin
            walk   = (run_x > run_y) ? MODE_XMAJ : MODE_YMAJ;
            pen_x  = w.start_x;
            pen_y  = w.start_y;
            goal_x = w.end_x;
            goal_y = w.end_y;
         end
         plot_next();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
         pen_x          = '0;
         pen_y          = '0;
         goal_x         = '0;
         goal_y         = '0;
         run_x          = '0;
         run_y          = '0;
         err_sum        = 0;
         back_x         = 1'b0;
         back_y         = 1'b0;
         drawing        = 1'b0;
         ink            = 1'b0;
         walk           = MODE_VERT;
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected pixel word: x=%0d y=%0d colour=%0b last=%0b",
                           rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.pixel_color,
                           rsp_data.last);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.pixel_x !== want.pixel_x || rsp_data.pixel_y !== want.pixel_y ||
                   rsp_data.pixel_color !== want.pixel_color || rsp_data.last !== want.last)
               begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Pixel mismatch: expected x=%0d y=%0d colour=%0b last=%0b,",
                              want.pixel_x, want.pixel_y, want.pixel_color, want.last,
                              " got x=%0d y=%0d colour=%0b last=%0b",
                              rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.pixel_color,
                              rsp_data.last);
               end
            end
         end
         if (req_valid && req_ready) trace_request(req_data);
      end
      pixels_pending = expected_pixels.size();
   end

endmodule

FILE: dv/line_pixel_rasterizer_tb.sv
// Testbench top for the line pixel rasteriser: drives directed and random line words,
// stalls the response side and gives the verdict. Depends on lpr_pkg,
// line_pixel_rasterizer and line_pixel_rasterizer_checker.
module line_pixel_rasterizer_tb;
   import lpr_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      mismatch_count;
   int      pixels_pending;
   int      word_count;
   int      line_left;
   int      big_lines;
   bit      calm;

   line_pixel_rasterizer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   line_pixel_rasterizer_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pixels_pending (pixels_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("line_pixel_rasterizer verification failed");
      $finish;
   end

   function automatic int line_pixels(coord_type sx, coord_type sy, coord_type ex,
                                      coord_type ey);
      int dx, dy;
      dx = (sx > ex) ? int'(sx) - int'(ex) : int'(ex) - int'(sx);
      dy = (sy > ey) ? int'(sy) - int'(ey) : int'(ey) - int'(sy);
      if (sx == ex) return dy + 1;
      if (sy == ey) return dx + 1;
      return (dx > dy) ? dx : dy;
   endfunction

   function automatic coord_type near_coord(coord_type c);
      int v;
      v = int'(c) + int'($urandom_range(24)) - 12;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return coord_type'(v);
   endfunction

   task automatic send_word(req_type w);
      calm = (word_count >= 300 && word_count < 420);
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_advance();
      req_type w;
      w.op      = OP_ADVANCE;
      w.start_x = coord_type'($urandom_range(255));
      w.start_y = coord_type'($urandom_range(255));
      w.end_x   = coord_type'($urandom_range(255));
      w.end_y   = coord_type'($urandom_range(255));
      w.color   = 1'($urandom_range(1));
      send_word(w);
      if (line_left > 0) begin
         word_count++;
         line_left--;
      end
   endtask

   task automatic draw_line(coord_type sx, coord_type sy, coord_type ex, coord_type ey,
                            logic c, int adv);
      req_type w;
      w.op      = OP_START;
      w.start_x = sx;
      w.start_y = sy;
      w.end_x   = ex;
      w.end_y   = ey;
      w.color   = c;
      send_word(w);
      word_count++;
      line_left = line_pixels(sx, sy, ex, ey) - 1;
      repeat (adv) send_advance();
   endtask

   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && word_count >= 150) begin
            hold_done = 1'b1;
            hold_left = 299;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 11);
         end
      end
   end

   initial begin
      coord_type sx, sy, ex, ey;
      int        pick, len, adv;
      word_count = 0;
      line_left  = 0;
      big_lines  = 0;
      calm       = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_advance();
      draw_line(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1);
      draw_line(8'd255, 8'd250, 8'd255, 8'd255, 1'b0, 5);
      draw_line(8'd255, 8'd0, 8'd251, 8'd0, 1'b1, 4);
      draw_line(8'd255, 8'd255, 8'd252, 8'd254, 1'b0, 2);
      draw_line(8'd0, 8'd0, 8'd2, 8'd5, 1'b1, 1);
      draw_line(8'd10, 8'd20, 8'd13, 8'd17, 1'b1, 2);
      draw_line(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 0);

      while (word_count < 720) begin
         pick = $urandom_range(99);
         sx   = coord_type'($urandom_range(255));
         sy   = coord_type'($urandom_range(255));
         if (pick < 2 && big_lines < 3) begin
            big_lines++;
            ex = coord_type'($urandom_range(255));
            ey = coord_type'($urandom_range(255));
         end else begin
            ex = near_coord(sx);
            ey = near_coord(sy);
            if ($urandom_range(99) < 15) ex = sx;
            else if ($urandom_range(99) < 18) ey = sy;
         end
         len = line_pixels(sx, sy, ex, ey);
         if (pick < 75)
            adv = len - 1 + (($urandom_range(3) == 0) ? int'($urandom_range(2)) : 0);
         else
            adv = $urandom_range(len - 1);
         if (pick >= 90) repeat ($urandom_range(1, 3)) send_advance();
         else draw_line(sx, sy, ex, ey, 1'($urandom_range(1)), adv);
      end
      req_valid <= 1'b0;

      @(negedge clock);
      while (pixels_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("line_pixel_rasterizer verification clean");
      end else begin
         $display("line_pixel_rasterizer verification failed");
      end
      $finish;
   end

endmodule
